FILE: rtl/core/obs_pkg.sv
// Shared types and constants for the overwriting bounded stack.
`timescale 1ns / 1ps
package obs_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY   = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_ENTRY_LIMIT      = 1'b0;
  localparam logic REG_INITIAL_CAPACITY = 1'b1;

  localparam logic [CNT_W-1:0] ENTRY_LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   pop_value;
    logic [CNT_W-1:0]    length;
    logic [CNT_W-1:0]    capacity;
    logic                dropped_oldest;
  } rsp_t;

  // Per-transaction result info, minus the popped word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    length;
    logic [CNT_W-1:0]    capacity;
    logic                dropped_oldest;
    logic                popped;
  } meta_t;

  typedef struct packed {
    logic             en;
    logic             idx;
    logic [CNT_W-1:0] data;
  } cfg_wr_t;

endpackage

FILE: rtl/core/overwriting_bounded_stack_unit.sv
// Overwriting bounded stack: top level with result pipeline and APB registers.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries push, pop and clear
//   transactions; rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   result per transaction, in order: status, popped word, length after the
//   operation, capacity high-water mark and an oldest-entry-dropped flag.
//   The accepting edge updates the ring, stores the result info in the middle
//   stage and does the registered RAM read; rsp_valid rises when the output
//   register is loaded from the middle stage. Throughput: one transaction per
//   cycle while rsp_stall is low. When rsp_stall is high the output register
//   holds; one more result waits in the middle stage, after which req_stall
//   goes high.
//   Reset (rst, synchronous) empties the stack, sets the entry limit to 16 and
//   initial_capacity and the mark to zero. Entry contents are not cleared.
//   APB registers: 0x0 entry limit, 0x4 initial_capacity (5 bits each);
//   write them only while no transaction is in flight.
`timescale 1ns / 1ps
module overwriting_bounded_stack_unit import obs_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  acc;
  logic                  s1_valid, s1_move;
  meta_t                 s1_meta, meta;
  cfg_wr_t               cfg_wr;
  logic [CNT_W-1:0]      max_raw, init_raw;
  logic                  we, re;
  logic [PTR_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign acc       = req_valid && !req_stall;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata[CNT_W-1:0];
  assign prdata = (paddr[2] == REG_INITIAL_CAPACITY) ? APB_DW'(init_raw) : APB_DW'(max_raw);

  obs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .req      (req),
    .cfg_wr   (cfg_wr),
    .max_raw  (max_raw),
    .init_raw (init_raw),
    .meta     (meta),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr)
  );

  obs_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PTR_W      (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta <= meta;
    end
    if (s1_move) begin
      rsp.status         <= s1_meta.status;
      rsp.pop_value      <= s1_meta.popped ? WORD_W'(rdata) : '0;
      rsp.length         <= s1_meta.length;
      rsp.capacity       <= s1_meta.capacity;
      rsp.dropped_oldest <= s1_meta.dropped_oldest;
    end
  end

  // length never passes the high-water mark
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.length <= rsp.capacity)
    else $error("length above capacity mark");

  // a drop only happens on a successful push into a non-empty stack
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dropped_oldest |-> rsp.status == ST_OK && rsp.length != '0)
    else $error("drop flag on a failed or empty result");

  // pop on empty must leave the stack empty
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_POP_EMPTY |-> rsp.length == '0)
    else $error("pop-empty status with nonzero length");

  // a held middle stage must block new transactions
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |-> !acc)
    else $error("transaction accepted over a held stage");

endmodule

FILE: rtl/core/obs_store.sv
// Entry ring storage: one write port, one registered read port.
`timescale 1ns / 1ps
module obs_store import obs_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [PTR_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [PTR_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/obs_ctrl.sv
// Top pointer, count, capacity mark and configuration registers.
`timescale 1ns / 1ps
module obs_ctrl import obs_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  acc,
  input  req_t                  req,
  input  cfg_wr_t               cfg_wr,
  output logic [CNT_W-1:0]      max_raw,
  output logic [CNT_W-1:0]      init_raw,
  output meta_t                 meta,
  output logic                  we,
  output logic [PTR_W-1:0]      waddr,
  output logic [DATA_WIDTH-1:0] wdata,
  output logic                  re,
  output logic [PTR_W-1:0]      raddr
);

  localparam int MAXC = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] MAX_CLAMP = CNT_W'(MAXC);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  function automatic logic [CNT_W-1:0] clamp_max(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] r;
    if (raw == '0) begin
      r = CNT_W'(1);
    end else if (raw > MAX_CLAMP) begin
      r = MAX_CLAMP;
    end else begin
      r = raw;
    end
    return r;
  endfunction

  logic [PTR_W-1:0]      top, top_next, top_inc, top_dec;
  logic [CNT_W-1:0]      count, count_next, mark, mark_next;
  logic [CNT_W-1:0]      max_raw_next, init_raw_next;
  logic [CNT_W-1:0]      eff_max, new_max, new_init;
  logic [DATA_WIDTH-1:0] word;

  always_comb begin
    eff_max  = clamp_max(max_raw);
    word     = DATA_WIDTH'(req.push_value);
    top_inc  = (top == LAST_SLOT) ? '0 : PTR_W'(top + PTR_W'(1));
    top_dec  = (top == '0) ? LAST_SLOT : PTR_W'(top - PTR_W'(1));
    new_max  = clamp_max(cfg_wr.data);
    new_init = (cfg_wr.data > eff_max) ? eff_max : cfg_wr.data;

    top_next      = top;
    count_next    = count;
    mark_next     = mark;
    max_raw_next  = max_raw;
    init_raw_next = init_raw;

    meta.status         = ST_OK;
    meta.dropped_oldest = 1'b0;
    meta.popped         = 1'b0;
    we    = 1'b0;
    waddr = top_inc;
    wdata = word;
    re    = 1'b0;
    raddr = top;

    if (acc) begin
      unique case (req.cmd)
        CMD_PUSH: begin
          if (word == '0) begin
            meta.status = ST_ZERO_REJECT;
          end else begin
            top_next = top_inc;
            we       = 1'b1;
            if (count >= eff_max) begin
              count_next          = eff_max;
              meta.dropped_oldest = 1'b1;
            end else begin
              count_next = CNT_W'(count + CNT_W'(1));
            end
            if (count_next > mark) begin
              mark_next = count_next;
            end
          end
        end
        CMD_POP: begin
          if (count == '0) begin
            meta.status = ST_POP_EMPTY;
          end else begin
            re          = 1'b1;
            meta.popped = 1'b1;
            top_next    = top_dec;
            count_next  = CNT_W'(count - CNT_W'(1));
          end
        end
        CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end else if (cfg_wr.en) begin
      if (cfg_wr.idx == REG_ENTRY_LIMIT) begin
        max_raw_next = cfg_wr.data;
        // shrinking the limit drops the oldest entries and cuts the mark
        if (count > new_max) begin
          count_next = new_max;
        end
        if (mark > new_max) begin
          mark_next = new_max;
        end
      end else begin
        init_raw_next = cfg_wr.data;
        if (new_init > mark) begin
          mark_next = new_init;
        end
      end
    end

    meta.length   = count_next;
    meta.capacity = mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= '0;
      count    <= '0;
      mark     <= '0;
      max_raw  <= ENTRY_LIMIT_RESET;
      init_raw <= '0;
    end else begin
      top      <= top_next;
      count    <= count_next;
      mark     <= mark_next;
      max_raw  <= max_raw_next;
      init_raw <= init_raw_next;
    end
  end

endmodule
